@@ rtl/core/sehc_pkg.sv @@
`timescale 1ns / 1ps

package sehc_pkg;

    localparam int MAGIC_BYTES      = 4;
    localparam int NONCE_BYTES      = 12;
    localparam int TAG_BYTES        = 16;
    localparam int SESSION_ID_BYTES = 16;

    // first offset after length and magic
    localparam int HDR0 = 4 + MAGIC_BYTES;

    localparam int OFF_W  = 32;
    localparam int ACC_W  = 36;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;

    localparam logic [OFF_W-1:0] OFF_MAX       = '1;
    localparam logic [OFF_W-1:0] OFF_LEN_LAST  = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_MAGIC     = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFF_HDR0      = OFF_W'(HDR0);
    localparam logic [OFF_W-1:0] OFF_VER_LAST  = OFF_W'(HDR0 + 3);
    localparam logic [OFF_W-1:0] OFF_FIELDS    = OFF_W'(HDR0 + 4);
    // last byte of each 32-bit header word after the version
    localparam logic [OFF_W-1:0] OFF_F0        = OFF_W'(HDR0 + 7);
    localparam logic [OFF_W-1:0] OFF_F1        = OFF_W'(HDR0 + 11);
    localparam logic [OFF_W-1:0] OFF_F2        = OFF_W'(HDR0 + 15);
    localparam logic [OFF_W-1:0] OFF_F3        = OFF_W'(HDR0 + 19);
    localparam logic [OFF_W-1:0] OFF_F4        = OFF_W'(HDR0 + 23);
    localparam logic [OFF_W-1:0] OFF_F5        = OFF_W'(HDR0 + 27);
    localparam logic [OFF_W-1:0] OFF_LEG_END   = OFF_W'(HDR0 + 16);
    localparam logic [OFF_W-1:0] OFF_ID_START  = OFF_W'(HDR0 + 28);
    localparam logic [OFF_W-1:0] OFF_ID_LIMIT  = OFF_W'(HDR0 + 28 + SESSION_ID_BYTES);

    localparam logic [1:0] MODE_LEGACY  = 2'd1;
    localparam logic [1:0] MODE_SESSION = 2'd2;

    typedef enum logic [2:0] {
        REGION_LENGTH  = 3'd0,
        REGION_MAGIC   = 3'd1,
        REGION_HEADER  = 3'd2,
        REGION_SESSION = 3'd3,
        REGION_NONCE   = 3'd4,
        REGION_TAG     = 3'd5,
        REGION_CIPHER  = 3'd6,
        REGION_EXCESS  = 3'd7
    } region_t;

    typedef enum logic [3:0] {
        VERDICT_OK        = 4'd0,
        VERDICT_SHORT     = 4'd1,
        VERDICT_LENGTH    = 4'd2,
        VERDICT_MAGIC     = 4'd3,
        VERDICT_TRUNCATED = 4'd4,
        VERDICT_VERSION   = 4'd5,
        VERDICT_METADATA  = 4'd6,
        VERDICT_NONCE_TAG = 4'd7,
        VERDICT_PAYLOAD   = 4'd8,
        VERDICT_MODE      = 4'd9,
        VERDICT_ID        = 4'd10
    } verdict_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MAGIC   = 3'd0,
        CFG_LEGACY  = 3'd1,
        CFG_SESSION = 3'd2,
        CFG_MODE    = 3'd3,
        CFG_ID_HIGH = 3'd4,
        CFG_ID_LOW  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [31:0] legacy_version;
        logic [31:0] session_version;
        logic [1:0]  accept_mode;
        logic [63:0] expected_id_high;
        logic [63:0] expected_id_low;
    } cfg_t;

    // packet state after one byte, handed to the classify stage
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [OFF_W-1:0] offset;
        logic [31:0]      version;
        logic [31:0]      sid_length;
        logic [63:0]      seq_number;
        logic [31:0]      nonce_length;
        logic [31:0]      tag_length;
        logic [31:0]      cipher_length;
        logic [32:0]      nt_sum;
        logic [33:0]      ntc_sum;
        logic [31:0]      content_length;
        logic             magic_ok;
        logic             id_ok;
    } snap_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx, input logic [31:0] word);
        int          sh;
        logic [31:0] t;
        sh = MAGIC_BYTES - 1 - int'(idx);
        t  = word >> (8 * sh);
        // magic bytes above bit 31 are expected as zero
        if (sh > 3 || sh < 0) begin
            return 8'd0;
        end
        return t[7:0];
    endfunction

    function automatic logic [7:0] id_byte(input logic [3:0] k, input logic [63:0] hi,
                                           input logic [63:0] lo);
        logic [127:0] id;
        logic [3:0]   inv;
        id  = {hi, lo};
        inv = 4'd15 - k;
        id  = id >> {inv, 3'b000};
        return id[7:0];
    endfunction

endpackage

@@ rtl/core/secure_envelope_header_checker_core.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_packet_byte, s_end_of_packet
// m_      | out       | m_valid / m_ready  | m_byte_out, m_region, m_final_mark,
//         |           |                    | m_verdict, m_session_form,
//         |           |                    | m_sequence_value, m_cipher_bytes
// cfg_    | in        | cfg_we             | cfg_addr, cfg_wdata
//
// One byte per cycle sustained while m_ready is high; an accepted request passes through
// the middle stage register and then the output register, where its result is valid.
// The figure is set by the packet tracker, whose state register updates once per byte.
// Synchronous active-low reset clears packet state and both stage valids and
// loads the configuration reset values.
// With m_ready low the result holds, one more request fills the middle stage,
// then s_ready drops.

module secure_envelope_header_checker_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_packet_byte,
    input  logic                       s_end_of_packet,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_byte_out,
    output logic [2:0]                 m_region,
    output logic                       m_final_mark,
    output logic [3:0]                 m_verdict,
    output logic                       m_session_form,
    output logic [63:0]                m_sequence_value,
    output logic [31:0]                m_cipher_bytes,
    input  logic                       cfg_we,
    input  logic [sehc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [sehc_pkg::CFG_DW-1:0] cfg_wdata
);
    import sehc_pkg::*;

    cfg_t     cfg_reg;
    snap_t    snap, s1_snap_reg;
    region_t  region;
    verdict_t verdict;
    logic     session_form;

    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_free, s1_adv, accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word       <= 32'd0;
            cfg_reg.legacy_version   <= 32'd1;
            cfg_reg.session_version  <= 32'd2;
            cfg_reg.accept_mode      <= 2'd0;
            cfg_reg.expected_id_high <= 64'd0;
            cfg_reg.expected_id_low  <= 64'd0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_MAGIC:   cfg_reg.magic_word       <= cfg_wdata[31:0];
                CFG_LEGACY:  cfg_reg.legacy_version   <= cfg_wdata[31:0];
                CFG_SESSION: cfg_reg.session_version  <= cfg_wdata[31:0];
                CFG_MODE:    cfg_reg.accept_mode      <= cfg_wdata[1:0];
                CFG_ID_HIGH: cfg_reg.expected_id_high <= cfg_wdata;
                CFG_ID_LOW:  cfg_reg.expected_id_low  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    sehc_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .packet_byte   (s_packet_byte),
        .end_of_packet (s_end_of_packet),
        .cfg           (cfg_reg),
        .snap          (snap)
    );

    sehc_classify u_classify (
        .snap         (s1_snap_reg),
        .cfg          (cfg_reg),
        .region       (region),
        .verdict      (verdict),
        .session_form (session_form)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_snap_reg <= snap;
        end
        if (s1_adv) begin
            m_byte_out       <= s1_snap_reg.data;
            m_region         <= region;
            m_final_mark     <= s1_snap_reg.last;
            m_verdict        <= verdict;
            m_session_form   <= session_form;
            m_sequence_value <= s1_snap_reg.seq_number;
            m_cipher_bytes   <= s1_snap_reg.cipher_length;
        end
    end

    assign m_valid = m_valid_reg;

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg && m_byte_out == $past(s1_snap_reg.data))
        else $error("middle stage advanced without a result");

    a_verdict_final_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_final_mark |-> m_verdict == VERDICT_OK)
        else $error("verdict on a non-final result");

    a_session_region_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_region == REGION_SESSION |-> m_session_form)
        else $error("session id region outside session form");

endmodule

@@ rtl/core/sehc_track.sv @@
`timescale 1ns / 1ps

module sehc_track (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [7:0]      packet_byte,
    input  logic            end_of_packet,
    input  sehc_pkg::cfg_t  cfg,
    output sehc_pkg::snap_t snap
);
    import sehc_pkg::*;

    localparam logic [3:0] ID_LSB = OFF_ID_START[3:0];

    logic [OFF_W-1:0] off_reg, off_next;
    logic [63:0]      shift_reg, shift_next;
    logic [31:0]      clen_reg, clen_next;
    logic [31:0]      ver_reg, ver_next;
    logic [31:0]      sid_reg, sid_next;
    logic [63:0]      seq_reg, seq_next;
    logic [31:0]      nonce_reg, nonce_next;
    logic [31:0]      tag_reg, tag_next;
    logic [31:0]      cipher_reg, cipher_next;
    logic [32:0]      nt_reg, nt_next;
    logic [33:0]      ntc_reg, ntc_next;
    logic             magic_ok_reg, magic_ok_next;
    logic             id_ok_reg, id_ok_next;

    logic        is_legacy, is_session, id_zone;
    logic [2:0]  magic_idx;
    logic [3:0]  id_idx;
    logic [34:0] id_end;

    always_comb begin
        shift_next    = {shift_reg[55:0], packet_byte};
        clen_next     = clen_reg;
        ver_next      = ver_reg;
        sid_next      = sid_reg;
        seq_next      = seq_reg;
        nonce_next    = nonce_reg;
        tag_next      = tag_reg;
        cipher_next   = cipher_reg;
        nt_next       = nt_reg;
        ntc_next      = ntc_reg;
        magic_ok_next = magic_ok_reg;
        id_ok_next    = id_ok_reg;

        is_legacy  = (ver_reg == cfg.legacy_version);
        is_session = !is_legacy && (ver_reg == cfg.session_version);
        magic_idx  = 3'(off_reg - OFF_MAGIC);
        id_idx     = off_reg[3:0] - ID_LSB;
        id_end     = 35'(OFF_ID_START) + {3'b000, sid_reg};
        id_zone    = (off_reg >= OFF_ID_START) && ({3'b000, off_reg} < id_end)
                     && (off_reg < OFF_ID_LIMIT);

        if (off_reg == OFF_LEN_LAST) begin
            clen_next = shift_next[31:0];
        end
        if (off_reg >= OFF_MAGIC && off_reg < OFF_HDR0) begin
            if (packet_byte != magic_byte(magic_idx, cfg.magic_word)) begin
                magic_ok_next = 1'b0;
            end
        end
        if (off_reg == OFF_VER_LAST) begin
            ver_next = shift_next[31:0];
        end

        if (is_legacy) begin
            if (off_reg == OFF_F0) begin
                nonce_next = shift_next[31:0];
            end else if (off_reg == OFF_F1) begin
                tag_next = shift_next[31:0];
                nt_next  = {1'b0, nonce_reg} + {1'b0, shift_next[31:0]};
            end else if (off_reg == OFF_F2) begin
                cipher_next = shift_next[31:0];
                ntc_next    = {1'b0, nt_reg} + {2'b00, shift_next[31:0]};
            end
        end else if (is_session) begin
            // the 64-bit sequence number spans two header words
            if (off_reg == OFF_F0) begin
                sid_next = shift_next[31:0];
            end else if (off_reg == OFF_F2) begin
                seq_next = shift_next;
            end else if (off_reg == OFF_F3) begin
                nonce_next = shift_next[31:0];
            end else if (off_reg == OFF_F4) begin
                tag_next = shift_next[31:0];
                nt_next  = {1'b0, nonce_reg} + {1'b0, shift_next[31:0]};
            end else if (off_reg == OFF_F5) begin
                cipher_next = shift_next[31:0];
                ntc_next    = {1'b0, nt_reg} + {2'b00, shift_next[31:0]};
            end
            if (id_zone && packet_byte != id_byte(id_idx, cfg.expected_id_high,
                                                  cfg.expected_id_low)) begin
                id_ok_next = 1'b0;
            end
        end

        // huge packets count as 2^32 bytes
        off_next = (off_reg == OFF_MAX) ? off_reg : off_reg + OFF_W'(1);

        snap.data           = packet_byte;
        snap.last           = end_of_packet;
        snap.offset         = off_reg;
        snap.version        = ver_next;
        snap.sid_length     = sid_next;
        snap.seq_number     = seq_next;
        snap.nonce_length   = nonce_next;
        snap.tag_length     = tag_next;
        snap.cipher_length  = cipher_next;
        snap.nt_sum         = nt_next;
        snap.ntc_sum        = ntc_next;
        snap.content_length = clen_next;
        snap.magic_ok       = magic_ok_next;
        snap.id_ok          = id_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_packet)) begin
            off_reg      <= '0;
            shift_reg    <= '0;
            clen_reg     <= '0;
            ver_reg      <= '0;
            sid_reg      <= '0;
            seq_reg      <= '0;
            nonce_reg    <= '0;
            tag_reg      <= '0;
            cipher_reg   <= '0;
            nt_reg       <= '0;
            ntc_reg      <= '0;
            magic_ok_reg <= 1'b1;
            id_ok_reg    <= 1'b1;
        end else if (accept) begin
            off_reg      <= off_next;
            shift_reg    <= shift_next;
            clen_reg     <= clen_next;
            ver_reg      <= ver_next;
            sid_reg      <= sid_next;
            seq_reg      <= seq_next;
            nonce_reg    <= nonce_next;
            tag_reg      <= tag_next;
            cipher_reg   <= cipher_next;
            nt_reg       <= nt_next;
            ntc_reg      <= ntc_next;
            magic_ok_reg <= magic_ok_next;
            id_ok_reg    <= id_ok_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_packet |=> off_reg == '0 && magic_ok_reg && id_ok_reg)
        else $error("packet state not cleared after last byte");

    a_offset_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !end_of_packet && off_reg != OFF_MAX
        |=> off_reg == $past(off_reg) + OFF_W'(1))
        else $error("byte offset did not advance");

endmodule

@@ rtl/core/sehc_classify.sv @@
`timescale 1ns / 1ps

module sehc_classify (
    input  sehc_pkg::snap_t    snap,
    input  sehc_pkg::cfg_t     cfg,
    output sehc_pkg::region_t  region,
    output sehc_pkg::verdict_t verdict,
    output logic               session_form
);
    import sehc_pkg::*;

    localparam logic [ACC_W-1:0] A_FOUR     = ACC_W'(4);
    localparam logic [ACC_W-1:0] A_HDR0     = ACC_W'(HDR0);
    localparam logic [ACC_W-1:0] A_VER_END  = ACC_W'(HDR0 + 4);
    localparam logic [ACC_W-1:0] A_LEG_END  = ACC_W'(HDR0 + 16);
    localparam logic [ACC_W-1:0] A_SESS_HDR = ACC_W'(HDR0 + 28);

    logic             is_legacy, is_session;
    logic [ACC_W-1:0] off, size, sess_end, base, pos, hdr_end, total, ntc, nt;

    always_comb begin
        is_legacy  = (snap.version == cfg.legacy_version);
        is_session = !is_legacy && (snap.version == cfg.session_version);

        off      = {4'b0000, snap.offset};
        size     = off + ACC_W'(1);
        nt       = {3'b000, snap.nt_sum};
        ntc      = {2'b00, snap.ntc_sum};
        sess_end = A_SESS_HDR + {4'b0000, snap.sid_length};
        base     = is_legacy ? A_LEG_END : sess_end;
        pos      = off - base;

        session_form = (snap.offset >= OFF_VER_LAST) && is_session;

        if (off < A_FOUR) begin
            region = REGION_LENGTH;
        end else if (off < A_HDR0) begin
            region = REGION_MAGIC;
        end else if (off < A_VER_END) begin
            region = REGION_HEADER;
        end else if (!is_legacy && !is_session) begin
            region = REGION_EXCESS;
        end else if (is_legacy && off < A_LEG_END) begin
            region = REGION_HEADER;
        end else if (is_session && off < A_SESS_HDR) begin
            region = REGION_HEADER;
        end else if (is_session && off < sess_end) begin
            region = REGION_SESSION;
        end else if (pos < {4'b0000, snap.nonce_length}) begin
            region = REGION_NONCE;
        end else if (pos < nt) begin
            region = REGION_TAG;
        end else if (pos < ntc) begin
            region = REGION_CIPHER;
        end else begin
            region = REGION_EXCESS;
        end

        hdr_end = is_legacy ? A_LEG_END : sess_end;
        total   = hdr_end + ntc;

        if (!snap.last) begin
            verdict = VERDICT_OK;
        end else if (size < A_FOUR) begin
            verdict = VERDICT_SHORT;
        end else if (size != A_FOUR + {4'b0000, snap.content_length}) begin
            verdict = VERDICT_LENGTH;
        end else if (size < A_HDR0 || !snap.magic_ok) begin
            verdict = VERDICT_MAGIC;
        end else if (size < A_VER_END) begin
            verdict = VERDICT_TRUNCATED;
        end else if (!is_legacy && !is_session) begin
            verdict = VERDICT_VERSION;
        end else if (is_legacy && size < A_LEG_END) begin
            verdict = VERDICT_TRUNCATED;
        end else if (is_session && size < A_SESS_HDR) begin
            verdict = VERDICT_TRUNCATED;
        end else if (is_session && (snap.sid_length != 32'(SESSION_ID_BYTES)
                                    || snap.seq_number == 64'd0)) begin
            verdict = VERDICT_METADATA;
        end else if (is_session && size < sess_end) begin
            verdict = VERDICT_TRUNCATED;
        end else if (snap.nonce_length != 32'(NONCE_BYTES)
                     || snap.tag_length != 32'(TAG_BYTES)) begin
            verdict = VERDICT_NONCE_TAG;
        end else if (size != total) begin
            verdict = VERDICT_PAYLOAD;
        end else if (cfg.accept_mode == MODE_LEGACY && !is_legacy) begin
            verdict = VERDICT_MODE;
        end else if (cfg.accept_mode == MODE_SESSION
                     && snap.version != cfg.session_version) begin
            verdict = VERDICT_MODE;
        end else if (cfg.accept_mode == MODE_SESSION && (!is_session || !snap.id_ok)) begin
            // both versions equal lands here: legacy layout wins
            verdict = VERDICT_ID;
        end else begin
            verdict = VERDICT_OK;
        end
    end

endmodule
